>>> src/sdii_pkg.sv
// sdii_pkg: widths, op codes, register file map, series coefficients and the
// microcode table of the strapdown integrator sequencer
// depends on nothing; used by every module of the block
package sdii_pkg;

  localparam int DW        = 56;          // register file word, signed
  localparam int BW        = 36;          // multiplier operand, signed
  localparam int MW        = DW + 1;      // multiplicand after magnitude
  localparam int PW        = MW + BW;     // product accumulator
  localparam int NDW       = 80;          // dividend bits for the dt scaling
  localparam int DT_W      = 24;
  localparam int RA_W      = 7;
  localparam int RF_DEPTH  = 69;
  localparam int ROM_DEPTH = 256;
  localparam int PC_W      = 8;

  localparam logic [47:0] DT_MAX   = 48'd16777215;
  localparam logic [19:0] DIV_K    = 20'd1000000;
  localparam logic [19:0] DIV_HALF = 20'd500000;
  localparam logic [20:0] GRAV_RST = 21'd642908;

  // micro-op codes
  localparam logic [4:0] OP_END   = 5'd0;
  localparam logic [4:0] OP_LDK   = 5'd1;
  localparam logic [4:0] OP_IN    = 5'd2;
  localparam logic [4:0] OP_BR    = 5'd3;
  localparam logic [4:0] OP_AVG   = 5'd4;
  localparam logic [4:0] OP_MOV   = 5'd5;
  localparam logic [4:0] OP_ADD   = 5'd6;
  localparam logic [4:0] OP_SUB   = 5'd7;
  localparam logic [4:0] OP_SHL   = 5'd8;
  localparam logic [4:0] OP_CLAMP = 5'd9;
  localparam logic [4:0] OP_SAT32 = 5'd10;
  localparam logic [4:0] OP_SAT48 = 5'd11;
  localparam logic [4:0] OP_GRAV  = 5'd12;
  localparam logic [4:0] OP_MULR  = 5'd13;
  localparam logic [4:0] OP_SCALE = 5'd14;
  localparam logic [4:0] OP_SER   = 5'd15;
  localparam logic [4:0] OP_OUT   = 5'd16;

  // serial unit job kinds
  localparam logic [1:0] SK_MULR  = 2'd0;
  localparam logic [1:0] SK_SCALE = 2'd1;
  localparam logic [1:0] SK_SER   = 2'd2;

  // register file map
  localparam int R_PG  = 0;
  localparam int R_PA  = 3;
  localparam int R_O   = 6;
  localparam int R_V   = 15;
  localparam int R_P   = 18;
  localparam int R_G   = 21;
  localparam int R_A   = 24;
  localparam int R_MG  = 27;
  localparam int R_MA  = 30;
  localparam int R_TH  = 33;
  localparam int R_T   = 36;
  localparam int R_S2  = 45;
  localparam int R_SA  = 46;
  localparam int R_SB  = 47;
  localparam int R_R   = 48;
  localparam int R_C   = 57;
  localparam int R_X1  = 66;
  localparam int R_X2  = 67;
  localparam int R_ONE = 68;

  localparam logic [PC_W-1:0] PC_RUN = 8'd23;

  typedef struct packed {
    logic [4:0] op;
    logic [6:0] d;
    logic [6:0] a;
    logic [6:0] b;
    logic [7:0] k;
  } uop_t;

  typedef uop_t [ROM_DEPTH-1:0] urom_t;

  typedef struct packed {
    logic                 start;
    logic [1:0]           kind;
    logic [1:0]           off;
    logic signed [DW-1:0] a;
    logic [BW-1:0]        b;
    logic [DT_W-1:0]      dt;
  } ser_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] res;
  } ser_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [RA_W-1:0]      addr;
    logic signed [DW-1:0] data;
  } rf_wr_t;

  function automatic uop_t mk(logic [4:0] op, int d, int a, int b, int k);
    uop_t m;
    m.op = op;
    m.d  = 7'(d);
    m.a  = 7'(a);
    m.b  = 7'(b);
    m.k  = 8'(k);
    return m;
  endfunction

  // 1/n! in Q2.30
  function automatic logic signed [31:0] inv_fact(logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd1073741824;
      5'd1:    v = 32'sd1073741824;
      5'd2:    v = 32'sd536870912;
      5'd3:    v = 32'sd178956971;
      5'd4:    v = 32'sd44739243;
      5'd5:    v = 32'sd8947849;
      5'd6:    v = 32'sd1491308;
      5'd7:    v = 32'sd213044;
      5'd8:    v = 32'sd26631;
      5'd9:    v = 32'sd2959;
      5'd10:   v = 32'sd296;
      5'd11:   v = 32'sd27;
      5'd12:   v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // microcode: reset pass first, then the per-item program from PC_RUN
  function automatic urom_t build_rom();
    urom_t rom;
    int n, i, j, p, br1, br2, dd, tt;
    logic [4:0] pm;
    for (i = 0; i < ROM_DEPTH; i++) rom[i] = mk(OP_END, 0, 0, 0, 0);
    n = 0;
    for (i = 0; i < 3; i++) begin rom[n] = mk(OP_LDK, R_PG + i, 0, 0, 0); n++; end
    for (i = 0; i < 3; i++) begin rom[n] = mk(OP_LDK, R_PA + i, 0, 0, 0); n++; end
    for (i = 0; i < 9; i++) begin
      rom[n] = mk(OP_LDK, R_O + i, 0, 0, (i % 4 == 0) ? 1 : 0); n++;
    end
    for (i = 0; i < 3; i++) begin rom[n] = mk(OP_LDK, R_V + i, 0, 0, 0); n++; end
    for (i = 0; i < 3; i++) begin rom[n] = mk(OP_LDK, R_P + i, 0, 0, 0); n++; end
    rom[n] = mk(OP_LDK, R_ONE, 0, 0, 1); n++;
    rom[n] = mk(OP_END, 0, 0, 0, 0); n++;
    // per-item program
    for (i = 0; i < 6; i++) begin
      rom[n] = mk(OP_IN, (i < 3) ? R_G + i : R_A + i - 3, 0, 0, i); n++;
    end
    br1 = n; n++;
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_AVG, R_MG + i, R_PG + i, R_G + i, 0); n++;
      rom[n] = mk(OP_AVG, R_MA + i, R_PA + i, R_A + i, 0); n++;
    end
    rom[br1] = mk(OP_BR, 0, 0, 0, n);
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_MOV, R_PG + i, R_G + i, 0, 0); n++;
      rom[n] = mk(OP_MOV, R_PA + i, R_A + i, 0, 0); n++;
    end
    br2 = n; n++;
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_SHL, R_X1, R_MG + i, 0, 0); n++;
      rom[n] = mk(OP_SCALE, R_X1, R_X1, 0, 0); n++;
      rom[n] = mk(OP_CLAMP, R_TH + i, R_X1, 0, 0); n++;
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        rom[n] = mk(OP_MULR, R_T + 3 * i + j, R_TH + i, R_TH + j, 0); n++;
      end
    rom[n] = mk(OP_ADD, R_X1, R_T, R_T + 4, 0); n++;
    rom[n] = mk(OP_ADD, R_S2, R_X1, R_T + 8, 0); n++;
    rom[n] = mk(OP_SER, R_SA, R_S2, 0, 1); n++;
    rom[n] = mk(OP_SER, R_SB, R_S2, 0, 2); n++;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        if (i == j) begin
          rom[n] = mk(OP_SUB, R_X1, R_T + 4 * i, R_S2, 0); n++;
          rom[n] = mk(OP_MULR, R_X1, R_SB, R_X1, 0); n++;
          rom[n] = mk(OP_ADD, R_R + 4 * i, R_X1, R_ONE, 0); n++;
        end else begin
          rom[n] = mk(OP_MULR, R_R + 3 * i + j, R_SB, R_T + 3 * i + j, 0); n++;
        end
      end
    // skew part of the rotation
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       begin dd = 1; tt = 2; pm = OP_SUB; end
        1:       begin dd = 2; tt = 1; pm = OP_ADD; end
        2:       begin dd = 3; tt = 2; pm = OP_ADD; end
        3:       begin dd = 5; tt = 0; pm = OP_SUB; end
        4:       begin dd = 6; tt = 1; pm = OP_SUB; end
        default: begin dd = 7; tt = 0; pm = OP_ADD; end
      endcase
      rom[n] = mk(OP_MULR, R_X1, R_SA, R_TH + tt, 0); n++;
      rom[n] = mk(pm, R_R + dd, R_R + dd, R_X1, 0); n++;
    end
    for (i = 0; i < 9; i++) begin rom[n] = mk(OP_SAT32, R_R + i, R_R + i, 0, 0); n++; end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        rom[n] = mk(OP_MULR, R_X1, R_O + 3 * i, R_R + j, 0); n++;
        rom[n] = mk(OP_MULR, R_X2, R_O + 3 * i + 1, R_R + 3 + j, 0); n++;
        rom[n] = mk(OP_ADD, R_X1, R_X1, R_X2, 0); n++;
        rom[n] = mk(OP_MULR, R_X2, R_O + 3 * i + 2, R_R + 6 + j, 0); n++;
        rom[n] = mk(OP_ADD, R_X1, R_X1, R_X2, 0); n++;
        rom[n] = mk(OP_SAT32, R_C + 3 * i + j, R_X1, 0, 0); n++;
      end
    for (i = 0; i < 9; i++) begin rom[n] = mk(OP_MOV, R_O + i, R_C + i, 0, 0); n++; end
    for (i = 0; i < 3; i++) begin
      rom[n] = mk(OP_MULR, R_X1, R_O + 3 * i, R_MA, 0); n++;
      rom[n] = mk(OP_MULR, R_X2, R_O + 3 * i + 1, R_MA + 1, 0); n++;
      rom[n] = mk(OP_ADD, R_X1, R_X1, R_X2, 0); n++;
      rom[n] = mk(OP_MULR, R_X2, R_O + 3 * i + 2, R_MA + 2, 0); n++;
      rom[n] = mk(OP_ADD, R_X1, R_X1, R_X2, 0); n++;
      if (i == 2) begin rom[n] = mk(OP_GRAV, R_X1, R_X1, 0, 0); n++; end
      rom[n] = mk(OP_SCALE, R_X1, R_X1, 0, 0); n++;
      rom[n] = mk(OP_ADD, R_X1, R_V + i, R_X1, 0); n++;
      rom[n] = mk(OP_SAT48, R_V + i, R_X1, 0, 0); n++;
      rom[n] = mk(OP_SCALE, R_X1, R_V + i, 0, 0); n++;
      rom[n] = mk(OP_ADD, R_X1, R_P + i, R_X1, 0); n++;
      rom[n] = mk(OP_SAT48, R_P + i, R_X1, 0, 0); n++;
    end
    for (i = 0; i < 3; i++) begin rom[n] = mk(OP_OUT, 0, R_P + i, 0, i); n++; end
    rom[br2] = mk(OP_BR, 0, 0, 0, n);
    rom[n] = mk(OP_END, 0, 0, 0, 0);
    return rom;
  endfunction

  localparam urom_t UROM = build_rom();

endpackage

>>> src/strapdown_imu_integrator_unit.sv
// strapdown_imu_integrator_unit: microcoded sequencer around a register file
// and a bit-serial arithmetic unit; depends on sdii_pkg, sdii_rf, sdii_serial
//
//  channel  dir  width  contents
//  in_*     in   240    stamp_us, gyro_x/y/z, accel_x/y/z
//  out_*    out  144    pos_x, pos_y, pos_z
//  cfg_*    in   21     gravity_z
//
// an item that yields a position runs some 60 rounded multiplies (shift-and-add over
// the 36-bit multiplier, plus fetch and finish) and 9 dt scalings (a serial multiply
// then a restoring divide of the 80-bit dividend) in the one serial unit
// the first item and an item with zero dt only update the stored sample
// after reset a pass loads the initial state; in_tready stays low meanwhile
// a held result does not block the next item; only the output step of a new
// position waits for out_tready while the previous result is still held
module strapdown_imu_integrator_unit import sdii_pkg::*; #(
  parameter int SERIES_TERMS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [239:0] in_tdata,    // stamp_us, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,   // pos_x, pos_y, pos_z
  input  logic         cfg_wr_en,
  input  logic [20:0]  cfg_wr_data
);

  localparam logic [1:0] SQ_IDLE  = 2'd0;
  localparam logic [1:0] SQ_FETCH = 2'd1;
  localparam logic [1:0] SQ_EXEC  = 2'd2;
  localparam logic [1:0] SQ_WAIT  = 2'd3;

  localparam logic signed [DW-1:0] Q30_ONE = {{(DW-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [DW-1:0] Q30_NEG = -Q30_ONE;
  localparam logic signed [DW-1:0] S32_HI  = {{(DW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [DW-1:0] S32_LO  = {{(DW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [DW-1:0] S48_HI  = {{(DW-47){1'b0}}, {47{1'b1}}};
  localparam logic signed [DW-1:0] S48_LO  = {{(DW-47){1'b1}}, {47{1'b0}}};

  logic [1:0]      st_r, st_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            have_prev_r, have_prev_nxt;
  logic [47:0]     prev_stamp_r, prev_stamp_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [20:0]     gravity_r, gravity_nxt;
  logic [191:0]    in_hold_r, in_hold_nxt;
  logic [DT_W-1:0] dt_r, dt_nxt;
  logic            skip_r, skip_nxt;
  logic [47:0]     lane_r [3];
  logic [47:0]     lane_nxt [3];

  uop_t                 cu;
  logic signed [DW-1:0] ra, rb, simple_res;
  logic signed [DW:0]   avg_sum;
  logic [31:0]          in_word;
  logic [47:0]          stamp, diff;
  logic                 in_acc;
  rf_wr_t               rf_wr;
  ser_req_t             ser_req;
  ser_rsp_t             ser_rsp;

  assign cu     = UROM[pc_r];
  assign stamp  = in_tdata[47:0];
  assign diff   = stamp - prev_stamp_r;
  assign in_acc = in_tvalid && in_tready;

  sdii_rf u_rf (
    .clk       (clk),
    .wr        (rf_wr),
    .raddr_a   (cu.a),
    .raddr_b   (cu.b),
    .rdata_a_r (ra),
    .rdata_b_r (rb)
  );

  sdii_serial #(
    .SERIES_TERMS (SERIES_TERMS)
  ) u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ser_req),
    .rsp   (ser_rsp)
  );

  always_comb begin
    case (cu.k[2:0])
      3'd0:    in_word = in_hold_r[31:0];
      3'd1:    in_word = in_hold_r[63:32];
      3'd2:    in_word = in_hold_r[95:64];
      3'd3:    in_word = in_hold_r[127:96];
      3'd4:    in_word = in_hold_r[159:128];
      default: in_word = in_hold_r[191:160];
    endcase
    avg_sum = {ra[DW-1], ra} + {rb[DW-1], rb};
    case (cu.op)
      OP_LDK:   simple_res = (cu.k != 8'd0) ? Q30_ONE : '0;
      OP_IN:    simple_res = {{(DW-32){in_word[31]}}, in_word};
      OP_AVG:   simple_res = avg_sum[DW:1];
      OP_MOV:   simple_res = ra;
      OP_ADD:   simple_res = ra + rb;
      OP_SUB:   simple_res = ra - rb;
      OP_SHL:   simple_res = {ra[DW-15:0], 14'b0};
      OP_CLAMP: simple_res = (ra > Q30_ONE) ? Q30_ONE : ((ra < Q30_NEG) ? Q30_NEG : ra);
      OP_SAT32: simple_res = (ra > S32_HI) ? S32_HI : ((ra < S32_LO) ? S32_LO : ra);
      OP_SAT48: simple_res = (ra > S48_HI) ? S48_HI : ((ra < S48_LO) ? S48_LO : ra);
      OP_GRAV:  simple_res = ra - {{(DW-21){1'b0}}, gravity_r};
      default:  simple_res = ra;
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    pc_nxt         = pc_r;
    have_prev_nxt  = have_prev_r;
    prev_stamp_nxt = prev_stamp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    gravity_nxt    = cfg_wr_en ? cfg_wr_data : gravity_r;
    in_hold_nxt    = in_hold_r;
    dt_nxt         = dt_r;
    skip_nxt       = skip_r;
    lane_nxt       = lane_r;
    rf_wr.we       = 1'b0;
    rf_wr.addr     = cu.d;
    rf_wr.data     = simple_res;
    ser_req.start  = 1'b0;
    ser_req.kind   = (cu.op == OP_SCALE) ? SK_SCALE : ((cu.op == OP_SER) ? SK_SER : SK_MULR);
    ser_req.off    = cu.k[1:0];
    ser_req.a      = ra;
    ser_req.b      = rb[BW-1:0];
    ser_req.dt     = dt_r;
    case (st_r)
      SQ_IDLE: begin
        if (in_tvalid) begin
          in_hold_nxt    = in_tdata[239:48];
          skip_nxt       = !have_prev_r || (diff == 48'd0);
          dt_nxt         = (diff > DT_MAX) ? DT_MAX[DT_W-1:0] : diff[DT_W-1:0];
          have_prev_nxt  = 1'b1;
          prev_stamp_nxt = stamp;
          pc_nxt         = PC_RUN;
          st_nxt         = SQ_FETCH;
        end
      end
      SQ_FETCH: begin
        st_nxt = SQ_EXEC;
      end
      SQ_EXEC: begin
        case (cu.op)
          OP_END: begin
            st_nxt = SQ_IDLE;
          end
          OP_BR: begin
            pc_nxt = skip_r ? cu.k : pc_r + 8'd1;
            st_nxt = SQ_FETCH;
          end
          OP_MULR, OP_SCALE, OP_SER: begin
            ser_req.start = 1'b1;
            st_nxt        = SQ_WAIT;
          end
          OP_OUT: begin
            // the first lane waits for the previous item to leave
            if (!(cu.k == 8'd0 && out_valid_r && !out_tready)) begin
              lane_nxt[cu.k[1:0]] = ra[47:0];
              if (cu.k == 8'd2) begin
                out_valid_nxt = 1'b1;
              end
              pc_nxt = pc_r + 8'd1;
              st_nxt = SQ_FETCH;
            end
          end
          default: begin
            rf_wr.we = 1'b1;
            pc_nxt   = pc_r + 8'd1;
            st_nxt   = SQ_FETCH;
          end
        endcase
      end
      SQ_WAIT: begin
        if (ser_rsp.done) begin
          rf_wr.we   = 1'b1;
          rf_wr.data = ser_rsp.res;
          pc_nxt     = pc_r + 8'd1;
          st_nxt     = SQ_FETCH;
        end
      end
      default: begin
        st_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= SQ_FETCH;
      pc_r         <= '0;
      have_prev_r  <= 1'b0;
      prev_stamp_r <= '0;
      out_valid_r  <= 1'b0;
      gravity_r    <= GRAV_RST;
    end else begin
      st_r         <= st_nxt;
      pc_r         <= pc_nxt;
      have_prev_r  <= have_prev_nxt;
      prev_stamp_r <= prev_stamp_nxt;
      out_valid_r  <= out_valid_nxt;
      gravity_r    <= gravity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_hold_r <= in_hold_nxt;
    dt_r      <= dt_nxt;
    skip_r    <= skip_nxt;
    lane_r    <= lane_nxt;
  end

  assign in_tready  = (st_r == SQ_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lane_r[2], lane_r[1], lane_r[0]};

  a_start_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ser_req.start |-> (st_r == SQ_EXEC))
    else $error("serial job started outside execute");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ser_rsp.done |-> (st_r == SQ_WAIT))
    else $error("serial result arrived while not waiting");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == SQ_EXEC && $past(cu.op) == OP_OUT))
    else $error("result raised without an output step");

  a_wait_serial: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == SQ_WAIT) |-> (cu.op == OP_MULR || cu.op == OP_SCALE || cu.op == OP_SER))
    else $error("waiting on a step that uses no serial unit");

endmodule

>>> src/sdii_rf.sv
// sdii_rf: working register file of the integrator, one write port and two
// registered read ports; depends on sdii_pkg
module sdii_rf import sdii_pkg::*; (
  input  logic                 clk,
  input  rf_wr_t               wr,
  input  logic [RA_W-1:0]      raddr_a,
  input  logic [RA_W-1:0]      raddr_b,
  output logic signed [DW-1:0] rdata_a_r,
  output logic signed [DW-1:0] rdata_b_r
);

  logic signed [DW-1:0] mem [RF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

>>> src/sdii_serial.sv
// sdii_serial: bit-serial arithmetic unit: rounded Q30 multiply, dt scaling
// (serial multiply then restoring divide by 1e6) and the Horner series
// depends on sdii_pkg
module sdii_serial import sdii_pkg::*; #(
  parameter int SERIES_TERMS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ser_req_t req,
  output ser_rsp_t rsp
);

  localparam int NT = (SERIES_TERMS < 2) ? 2 : ((SERIES_TERMS > 8) ? 8 : SERIES_TERMS);
  localparam int LW = PW - 29;
  localparam logic [4:0] TOP_IDX  = 5'(2 * (NT - 1));
  localparam logic [2:0] SK_FIRST = 3'(NT - 2);
  localparam logic [6:0] MUL_LAST = 7'(BW - 1);
  localparam logic [6:0] DIV_LAST = 7'(NDW - 1);
  localparam logic signed [PW-1:0] RND_HALF = {{(PW-30){1'b0}}, 1'b1, 29'b0};
  localparam logic signed [LW-1:0] HI32 = {{(LW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [LW-1:0] LO32 = {{(LW-31){1'b1}}, {31{1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_POST = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DFIN = 3'd4;

  logic [2:0]           st_r, st_nxt;
  logic                 done_r, done_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [1:0]           off_r, off_nxt;
  logic                 neg_r, neg_nxt;
  logic [2:0]           sk_r, sk_nxt;
  logic signed [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0]        mplr_r, mplr_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic [NDW-1:0]       dv_r, dv_nxt;
  logic [19:0]          rem_r, rem_nxt;
  logic signed [DW-1:0] s2_r, s2_nxt;
  logic signed [DW-1:0] res_r, res_nxt;

  logic signed [MW-1:0] a_ext, a_mag;
  logic signed [31:0]   fk0, fk;
  logic signed [PW-1:0] addend, rsum;
  logic signed [PW-31:0] rq;
  logic signed [LW-1:0] dsub;
  logic signed [31:0]   sacc;
  logic [20:0]          trial;
  logic                 ge;
  logic signed [DW-1:0] qd;

  always_comb begin
    a_ext  = {req.a[DW-1], req.a};
    a_mag  = req.a[DW-1] ? -a_ext : a_ext;
    fk0    = inv_fact(TOP_IDX + {3'b000, req.off});
    fk     = inv_fact({1'b0, sk_r, 1'b0} + {3'b000, off_r});
    addend = mplr_r[0] ? ((cnt_r == MUL_LAST) ? -mcand_r : mcand_r) : '0;
    rsum   = acc_r + RND_HALF;
    rq     = rsum[PW-1:30];
    dsub   = {{(LW-32){fk[31]}}, fk} - {rq[PW-31], rq};
    if (dsub > HI32) begin
      sacc = 32'sh7FFFFFFF;
    end else if (dsub < LO32) begin
      sacc = 32'sh80000000;
    end else begin
      sacc = dsub[31:0];
    end
    trial = {rem_r, dv_r[NDW-1]};
    ge    = trial >= {1'b0, DIV_K};
    qd    = dv_r[DW-1:0];
  end

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    off_nxt   = off_r;
    neg_nxt   = neg_r;
    sk_nxt    = sk_r;
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    acc_nxt   = acc_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    s2_nxt    = s2_r;
    res_nxt   = res_r;
    case (st_r)
      S_IDLE: begin
        if (req.start) begin
          kind_nxt = req.kind;
          off_nxt  = req.off;
          s2_nxt   = req.a;
          neg_nxt  = req.a[DW-1];
          sk_nxt   = SK_FIRST;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          st_nxt   = S_MUL;
          case (req.kind)
            SK_SCALE: begin
              mcand_nxt = {{BW{1'b0}}, a_mag};
              mplr_nxt  = {{(BW-DT_W){1'b0}}, req.dt};
            end
            SK_SER: begin
              mcand_nxt = {{(PW-DW){req.a[DW-1]}}, req.a};
              mplr_nxt  = {{(BW-32){fk0[31]}}, fk0};
            end
            default: begin
              mcand_nxt = {{(PW-DW){req.a[DW-1]}}, req.a};
              mplr_nxt  = req.b;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt   = acc_r + addend;
        mcand_nxt = mcand_r <<< 1;
        mplr_nxt  = mplr_r >> 1;
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == MUL_LAST) begin
          st_nxt = S_POST;
        end
      end
      S_POST: begin
        case (kind_r)
          SK_SCALE: begin
            dv_nxt  = acc_r[NDW-1:0] + {{(NDW-20){1'b0}}, DIV_HALF};
            rem_nxt = '0;
            cnt_nxt = '0;
            st_nxt  = S_DIV;
          end
          SK_SER: begin
            if (sk_r == 3'd0) begin
              res_nxt  = {{(DW-32){sacc[31]}}, sacc};
              done_nxt = 1'b1;
              st_nxt   = S_IDLE;
            end else begin
              // next Horner step: s2 times the new partial sum
              sk_nxt    = sk_r - 3'd1;
              mcand_nxt = {{(PW-DW){s2_r[DW-1]}}, s2_r};
              mplr_nxt  = {{(BW-32){sacc[31]}}, sacc};
              acc_nxt   = '0;
              cnt_nxt   = '0;
              st_nxt    = S_MUL;
            end
          end
          default: begin
            res_nxt  = rq[DW-1:0];
            done_nxt = 1'b1;
            st_nxt   = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        rem_nxt = ge ? 20'(trial - {1'b0, DIV_K}) : trial[19:0];
        dv_nxt  = {dv_r[NDW-2:0], ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          st_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        res_nxt  = neg_r ? -qd : qd;
        done_nxt = 1'b1;
        st_nxt   = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    kind_r  <= kind_nxt;
    off_r   <= off_nxt;
    neg_r   <= neg_nxt;
    sk_r    <= sk_nxt;
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    acc_r   <= acc_nxt;
    dv_r    <= dv_nxt;
    rem_r   <= rem_nxt;
    s2_r    <= s2_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (st_r == S_IDLE))
    else $error("serial unit started while busy");

  a_done_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(st_r) == S_POST || $past(st_r) == S_DFIN))
    else $error("serial unit done without a finishing step");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (rem_r < DIV_K))
    else $error("divider remainder out of range");

endmodule

>>> tb/sdii_checker.sv
// sdii_checker: watches the sample, position and gravity ports of the strapdown
// integrator, predicts each position in fixed point and compares it
// depends on sdii_pkg for the gravity reset value only
module sdii_checker import sdii_pkg::*; #(
  parameter int SERIES_TERMS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [239:0] in_tdata,    // stamp_us, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,   // pos_x, pos_y, pos_z
  input  logic         cfg_wr_en,
  input  logic [20:0]  cfg_wr_data,
  output int           fails,
  output int           pending
);

  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint DT_CAP  = 64'sd16777215;

  typedef struct packed {
    logic [47:0] pz;
    logic [47:0] py;
    logic [47:0] px;
  } position_t;

  // 1/n! in Q2.30
  longint fact_q30 [0:16] = '{1073741824, 1073741824, 536870912, 178956971, 44739243,
                              8947849, 1491308, 213044, 26631, 2959, 296, 27, 2, 0, 0, 0, 0};

  logic [20:0] gravity;
  bit          have_prev;
  logic [47:0] prev_stamp;
  longint      prev_gyro [3];
  longint      prev_accel [3];
  longint      attitude [9];
  longint      vel [3];
  longint      pos [3];
  position_t   position_q [$];

  assign pending = position_q.size();

  function automatic longint rnd30(longint x);
    return (x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clip(longint x, int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  // round(v * dt / 1e6), half away from zero
  function automatic longint dt_scale(longint v, longint dt);
    longint unsigned mag, x, y, qx, rx, r;
    mag = v < 0 ? -v : v;
    x = (mag >> 24) * dt;
    y = (mag & 64'hFFFFFF) * dt;
    qx = x / 15625;
    rx = x % 15625;
    r = (qx << 18) + (rx * 16777216 + y + 500000) / 1000000;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint trig_series(longint s2, int off);
    int n;
    longint acc;
    n = SERIES_TERMS < 1 ? 1 : (SERIES_TERMS > 8 ? 8 : SERIES_TERMS);
    acc = fact_q30[2 * (n - 1) + off];
    for (int k = n - 2; k >= 0; k--) acc = clip(fact_q30[2 * k + off] - rnd30(s2 * acc), 32);
    return acc;
  endfunction

  task automatic integrate(input logic [239:0] d);
    logic [47:0] stamp, dt48;
    longint g[3], a[3], mg[3], ma[3], th[3], t[9], r[9], c[9];
    longint dt, s2, sa, sb, acc, sum;
    bit had;
    position_t p;
    stamp = d[47:0];
    for (int i = 0; i < 3; i++) begin
      g[i] = longint'($signed(d[48 + 32 * i +: 32]));
      a[i] = longint'($signed(d[144 + 32 * i +: 32]));
      mg[i] = (prev_gyro[i] + g[i]) >>> 1;
      ma[i] = (prev_accel[i] + a[i]) >>> 1;
    end
    dt48 = stamp - prev_stamp;
    had = have_prev;
    have_prev = 1;
    prev_stamp = stamp;
    for (int i = 0; i < 3; i++) begin
      prev_gyro[i] = g[i];
      prev_accel[i] = a[i];
    end
    if (!had || dt48 == 0) return;
    dt = longint'(dt48) > DT_CAP ? DT_CAP : longint'(dt48);
    for (int i = 0; i < 3; i++) begin
      th[i] = dt_scale(mg[i] * 16384, dt);
      if (th[i] > Q30_ONE) th[i] = Q30_ONE;
      if (th[i] < -Q30_ONE) th[i] = -Q30_ONE;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) t[3 * i + j] = rnd30(th[i] * th[j]);
    s2 = t[0] + t[4] + t[8];
    sa = trig_series(s2, 1);
    sb = trig_series(s2, 2);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[3 * i + j] = rnd30(sb * (t[3 * i + j] - (i == j ? s2 : 0))) + (i == j ? Q30_ONE : 0);
    r[1] -= rnd30(sa * th[2]);
    r[2] += rnd30(sa * th[1]);
    r[3] += rnd30(sa * th[2]);
    r[5] -= rnd30(sa * th[0]);
    r[6] -= rnd30(sa * th[1]);
    r[7] += rnd30(sa * th[0]);
    for (int i = 0; i < 9; i++) r[i] = clip(r[i], 32);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        sum = 0;
        for (int k = 0; k < 3; k++) sum += rnd30(attitude[3 * i + k] * r[3 * k + j]);
        c[3 * i + j] = clip(sum, 32);
      end
    attitude = c;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rnd30(attitude[3 * i + k] * ma[k]);
      if (i == 2) acc -= longint'(gravity);
      vel[i] = clip(vel[i] + dt_scale(acc, dt), 48);
      pos[i] = clip(pos[i] + dt_scale(vel[i], dt), 48);
    end
    p.px = pos[0][47:0];
    p.py = pos[1][47:0];
    p.pz = pos[2][47:0];
    position_q = {position_q, p};
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fails++;
  endtask

  always @(posedge clk) begin
    position_t got, want;
    if (!rst_n) begin
      gravity <= GRAV_RST;
      have_prev = 0;
      prev_stamp = '0;
      for (int i = 0; i < 3; i++) begin
        prev_gyro[i] = 0;
        prev_accel[i] = 0;
        vel[i] = 0;
        pos[i] = 0;
      end
      for (int i = 0; i < 9; i++) attitude[i] = (i % 4 == 0) ? Q30_ONE : 0;
    end else begin
      if (cfg_wr_en) gravity <= cfg_wr_data;
      if (in_tvalid && in_tready) integrate(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (position_q.size() == 0) begin
          $display("unexpected position item %h at %0t", out_tdata, $time);
          fails++;
        end else begin
          want = position_q.pop_front();
          if (got.px !== want.px) report("pos_x", got.px, want.px);
          if (got.py !== want.py) report("pos_y", got.py, want.py);
          if (got.pz !== want.pz) report("pos_z", got.pz, want.pz);
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
// tb: drives IMU samples and gravity settings into the strapdown integrator
// under random idling and stalls; depends on sdii_pkg, the block and sdii_checker
module tb import sdii_pkg::*;;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;    // stamp_us, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;   // pos_x, pos_y, pos_z
  logic         cfg_wr_en;
  logic [20:0]  cfg_wr_data;
  int           fails;
  int           pending;
  int           idle_pct;
  int           stall_pct;
  logic [47:0]  now_us;

  strapdown_imu_integrator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  sdii_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [239:0] sample(logic [47:0] st, int gx, int gy, int gz,
                                          int ax, int ay, int az);
    return {az, ay, ax, gz, gy, gx, st};
  endfunction

  task automatic send(input logic [239:0] w);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // the block must be idle, including any sample that yields no position
  task automatic set_gravity(input logic [20:0] g);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic int gyro_mild();
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  function automatic int accel_mild();
    return int'($urandom_range(0, 2621440)) - 1310720;
  endfunction

  task automatic send_random();
    int kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      now_us = now_us + $urandom_range(200, 5000);
      send(sample(now_us, gyro_mild(), gyro_mild(), gyro_mild(),
                  accel_mild(), accel_mild(), accel_mild()));
    end else begin
      // noise: odd timing and full-range readings
      case ($urandom_range(3))
        0: now_us = 48'({$urandom, $urandom});
        1: now_us = now_us - $urandom_range(0, 3000);
        2: now_us = 48'(now_us + {$urandom_range(0, 255), $urandom});
        default: now_us = now_us + $urandom_range(0, 1);
      endcase
      send(sample(now_us, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    logic [20:0] grav_set [4];
    rst_n       = 0;
    in_tvalid   = 0;
    in_tdata    = '0;
    cfg_wr_en   = 0;
    cfg_wr_data = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    now_us      = '0;
    grav_set    = '{21'd0, 21'd2097151, GRAV_RST, 21'($urandom)};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    set_gravity(GRAV_RST);

    // directed: first sample, zero rotation, repeated stamp, extremes, wrap, long gap
    send(sample(48'd0, 0, 0, 0, 0, 0, 0));
    send(sample(48'd1000, 0, 0, 0, 0, 0, 0));
    send(sample(48'd1000, 0, 0, 0, 65536, 0, 0));
    send(sample(48'd2000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send(sample(48'd3000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000));
    send(sample(48'd2500, 65536, -65536, 32768, 0, 0, 642908));
    send(sample(48'd20002500, 1000, 2000, -3000, 100, -100, 642908));
    send(sample(48'hFFFFFFFFFFFF, 0, 0, 0, 0, 0, 0));
    send(sample(48'd100, 0, 0, 0, 0, 0, 0));
    send(sample(48'd1100, 65536, 0, 0, 0, 0, 0));
    send(sample(48'd2100, 0, 65536, 0, 0, 0, 0));
    send(sample(48'd3100, 0, 0, 65536, 0, 0, 0));
    send(sample(48'd4100, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0));
    now_us = 48'd4100;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      set_gravity(grav_set[ph]);
      for (int n = 0; n < 150; n++) send_random();
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #400000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
src/sdii_pkg.sv
src/sdii_rf.sv
src/sdii_serial.sv
src/strapdown_imu_integrator_unit.sv
tb/sdii_checker.sv
tb/tb.sv
